@@ sv/alsq_pkg.sv @@
// shared types and constants for the animated layer sequencer
package alsq_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FRAME_COUNT    = 3'd0,
    CFG_PING_PONG      = 3'd1,
    CFG_LOOP_COUNT     = 3'd2,
    CFG_SCROLL_RATE_X  = 3'd3,
    CFG_SCROLL_RATE_Y  = 3'd4,
    CFG_DISTANCE       = 3'd5,
    CFG_SURFACE_WIDTH  = 3'd6,
    CFG_SURFACE_HEIGHT = 3'd7
  } cfg_index_t;

  // input item kinds
  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } kind_t;

  localparam int SubpixPerPixel = 256000;
  localparam int SubpixW        = 18;   // width of the sub-pixel remainder magnitude
  localparam int FracW          = 19;   // signed sub-pixel remainder
  localparam int ScrollSumW     = 57;   // signed rate * dt + remainder
  // 256000 = 125 << 11, the odd part is divided in 15-bit digits by reciprocal
  localparam int SubpixShift    = 11;
  localparam int SubpixOdd      = 125;
  localparam int DigitW         = 15;
  localparam int RecipMul       = 4294968;  // ceil(2^29 / 125), exact below 2^22
  localparam int RecipShift     = 29;
  localparam int DistShift      = 14;
  localparam int ScreenWidth    = 640;
  localparam int FrameLimit     = 64;

endpackage

@@ sv/alsq_ram.sv @@
// generic single-port-write ram with registered read
module alsq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/alsq_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
module alsq_div #(
  parameter int DW = 32,
  parameter int VW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW:0]   part;
  logic [VW:0]   diff;
  logic          take;

  always_comb begin
    part = {rem, quot[DW-1]};
    take = part >= {1'b0, divisor};
    diff = part - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= dividend;
        rem  <= '0;
      end else if (busy) begin
        rem  <= take ? diff[VW-1:0] : part[VW-1:0];
        quot <= {quot[DW-2:0], take};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/animated_layer_sequencer_core.sv @@
// a load item is done when it is taken; a tick goes through S_MUL, S_SUM, S_DIV1, S_WST, S_DIV2
// and S_FIN to a valid result, its time set by the scroll division and the 32-step wrap divider
// one item is worked on at a time; the next item is taken the cycle after the result
// is registered, even while that result waits
// synchronous reset restores the config defaults and clears animation and scroll state
// the frame delay memory is not cleared and holds garbage until loaded
module animated_layer_sequencer_core
  import alsq_pkg::*;
#(
  parameter int MAX_FRAMES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [31:0]        now_ms,
  input  logic signed [15:0] camera_x,
  input  logic signed [15:0] camera_y,
  input  logic signed [15:0] y_adjust,
  input  logic signed [15:0] base_x,
  input  logic signed [15:0] base_y,
  input  logic [5:0]         frame_slot,
  input  logic [15:0]        frame_delay,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         frame_index,
  output logic signed [31:0] dest_x,
  output logic signed [31:0] dest_y,
  output logic               second_copy,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam logic [6:0] FrameCap = 7'((MAX_FRAMES < FrameLimit) ? MAX_FRAMES : FrameLimit);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_DIV1, S_WST, S_DIV2, S_FIN
  } state_t;

  state_t state;

  // configuration
  logic [6:0]         frame_count;
  logic               ping_pong;
  logic signed [15:0] loop_count;
  logic signed [23:0] scroll_rate_x;
  logic signed [23:0] scroll_rate_y;
  logic [15:0]        distance;
  logic [11:0]        surface_width;
  logic [11:0]        surface_height;

  // layer state
  logic [5:0]             current_frame;
  logic                   play_backward;
  logic signed [15:0]     loops_left;
  logic [31:0]            next_due_ms;
  logic [31:0]            last_tick_ms;
  logic                   tick_seen;
  logic signed [FracW-1:0] frac_x, frac_y;
  logic [31:0]            pix_x, pix_y;

  // latched tick
  logic [31:0]        t_now;
  logic signed [15:0] t_cam_x, t_cam_y, t_yadj, t_bx, t_by;

  // work registers
  logic signed [ScrollSumW-1:0] prod_x, prod_y;
  logic signed [32:0]           mul_px, mul_py;
  logic signed [18:0]           par_x, par_y;
  logic                         sneg_x, sneg_y, wneg_x, wneg_y;
  logic [ScrollSumW-1:0]        mag_x, mag_y;
  logic [31:0]                  wmag_x, wmag_y;
  logic                         adv_pend;
  logic                         wdiv_start;

  logic in_xfer, out_xfer, scrolling;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign scrolling = (scroll_rate_x != '0) || (scroll_rate_y != '0);

  // frame delay memory
  logic          ram_we;
  logic [15:0]   ram_rdata;
  assign ram_we = in_xfer && (kind == KIND_LOAD) && (32'(frame_slot) < MAX_FRAMES);

  alsq_ram #(.WIDTH(16), .DEPTH(MAX_FRAMES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(frame_slot)),
    .wdata (frame_delay),
    .raddr (AW'(current_frame)),
    .rdata (ram_rdata)
  );

  // wrap dividers
  logic                  wdx_done, wdy_done;
  logic [31:0]           wq_x, wq_y;
  logic [11:0]           wr_x, wr_y;

  alsq_div #(.DW(32), .VW(12)) u_wdx (
    .clk(clk), .rst(rst), .start(wdiv_start), .dividend(wmag_x),
    .divisor(surface_width), .done(wdx_done), .quot(wq_x), .rem(wr_x)
  );
  alsq_div #(.DW(32), .VW(12)) u_wdy (
    .clk(clk), .rst(rst), .start(wdiv_start), .dividend(wmag_y),
    .divisor(surface_height), .done(wdy_done), .quot(wq_y), .rem(wr_y)
  );

  // scroll division: low 11 bits pass through, the rest is divided by 125 digit by digit
  logic [1:0]             sdig;
  logic [6:0]             srem_x, srem_y;
  logic [SubpixShift-1:0] slo_x, slo_y;
  logic [31:0]            sq_x, sq_y;
  logic [21:0]            sv_x, sv_y;
  logic [44:0]            rp_x, rp_y;
  logic [DigitW-1:0]      qd_x, qd_y;
  logic [21:0]            qm_x, qm_y, rdf_x, rdf_y;

  always_comb begin
    sv_x  = {srem_x, mag_x[ScrollSumW-2 -: DigitW]};
    sv_y  = {srem_y, mag_y[ScrollSumW-2 -: DigitW]};
    rp_x  = 45'(sv_x) * 45'(RecipMul);
    rp_y  = 45'(sv_y) * 45'(RecipMul);
    qd_x  = rp_x[RecipShift +: DigitW];
    qd_y  = rp_y[RecipShift +: DigitW];
    qm_x  = 22'(qd_x) * 22'(SubpixOdd);
    qm_y  = 22'(qd_y) * 22'(SubpixOdd);
    rdf_x = sv_x - qm_x;
    rdf_y = sv_y - qm_y;
  end

  // frame advance
  logic [6:0]         n_frames, last, curc;
  logic               adv, over, under, loops_pos;
  logic signed [15:0] loops_dec;
  logic [6:0]         cur_next;
  logic               back_next;
  logic signed [15:0] loops_next;

  always_comb begin
    n_frames   = (frame_count > FrameCap) ? FrameCap : frame_count;
    last       = n_frames - 7'd1;
    curc       = ({1'b0, current_frame} > last) ? last : {1'b0, current_frame};
    adv        = (n_frames != '0) && (loops_left != '0) && !(t_now < next_due_ms);
    over       = !play_backward && (curc == last);
    under      = play_backward && (curc == '0);
    loops_pos  = !loops_left[15] && (loops_left != '0);
    loops_dec  = loops_left - 16'sd1;
    back_next  = play_backward;
    loops_next = loops_left;
    cur_next   = play_backward ? curc - 7'd1 : curc + 7'd1;
    if (over) begin
      if (ping_pong) begin
        back_next = 1'b1;
        cur_next  = (last > 7'd1) ? last - 7'd1 : '0;
      end else begin
        if (loops_pos) begin
          loops_next = loops_dec;
        end
        cur_next = (loops_pos && loops_dec == '0) ? last : '0;
      end
    end else if (under) begin
      back_next = 1'b0;
      cur_next  = (last > '0) ? 7'd1 : '0;
      if (loops_pos) begin
        loops_next = loops_dec;
        if (loops_dec == '0) begin
          cur_next = '0;
        end
      end
    end
  end

  // scroll sums and parallax rounding
  logic signed [ScrollSumW-1:0] sum_x, sum_y;
  logic [ScrollSumW-1:0]        amag_x, amag_y;
  logic signed [32:0]           rnd_px, rnd_py;
  always_comb begin
    sum_x  = ScrollSumW'(frac_x) + prod_x;
    sum_y  = ScrollSumW'(frac_y) + prod_y;
    amag_x = sum_x[ScrollSumW-1] ? -sum_x : sum_x;
    amag_y = sum_y[ScrollSumW-1] ? -sum_y : sum_y;
    rnd_px = mul_px + (mul_px[32] ? 33'sd16383 : 33'sd0);
    rnd_py = mul_py + (mul_py[32] ? 33'sd16383 : 33'sd0);
  end

  // final placement
  logic [31:0]        sx, sy;
  logic signed [33:0] dx_full, dy_full;
  logic signed [31:0] dx32, dy32;
  logic               copy_flag;
  always_comb begin
    if (surface_width == '0) begin
      sx = pix_x;
    end else if (wneg_x && wr_x != '0) begin
      sx = 32'(surface_width - wr_x);
    end else begin
      sx = 32'(wr_x);
    end
    if (surface_height == '0) begin
      sy = pix_y;
    end else if (wneg_y && wr_y != '0) begin
      sy = 32'(surface_height - wr_y);
    end else begin
      sy = 32'(wr_y);
    end
    dx_full = 34'(t_bx) - 34'($signed(sx)) - 34'(par_x);
    dy_full = 34'(t_by) - 34'($signed(sy)) - 34'(par_y) + 34'(t_yadj);
    dx32    = dx_full[31:0];
    dy32    = dy_full[31:0];
    copy_flag = scrolling && (surface_width != '0) &&
                ((34'(dx32) + $signed({22'd0, surface_width})) < 34'(ScreenWidth));
  end

  logic [31:0] whole_x, whole_y, dt;
  assign whole_x = sneg_x ? -sq_x : sq_x;
  assign whole_y = sneg_y ? -sq_y : sq_y;
  assign dt      = t_now - last_tick_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      frame_count    <= '0;
      ping_pong      <= 1'b0;
      loop_count     <= -16'sd1;
      scroll_rate_x  <= '0;
      scroll_rate_y  <= '0;
      distance       <= 16'd16384;
      surface_width  <= '0;
      surface_height <= '0;
      current_frame  <= '0;
      play_backward  <= 1'b0;
      loops_left     <= -16'sd1;
      next_due_ms    <= '0;
      last_tick_ms   <= '0;
      tick_seen      <= 1'b0;
      frac_x         <= '0;
      frac_y         <= '0;
      pix_x          <= '0;
      pix_y          <= '0;
      out_valid      <= 1'b0;
      adv_pend       <= 1'b0;
      wdiv_start     <= 1'b0;
    end else begin
      wdiv_start <= 1'b0;
      // in the final state a transfer out always comes with a new result
      if (out_xfer && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_FRAME_COUNT:    frame_count    <= cfg_data[6:0];
          CFG_PING_PONG:      ping_pong      <= cfg_data[0];
          CFG_LOOP_COUNT:     loop_count     <= cfg_data[15:0];
          CFG_SCROLL_RATE_X:  scroll_rate_x  <= cfg_data[23:0];
          CFG_SCROLL_RATE_Y:  scroll_rate_y  <= cfg_data[23:0];
          CFG_DISTANCE:       distance       <= cfg_data[15:0];
          CFG_SURFACE_WIDTH:  surface_width  <= cfg_data[11:0];
          CFG_SURFACE_HEIGHT: surface_height <= cfg_data[11:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            t_now   <= now_ms;
            t_cam_x <= camera_x;
            t_cam_y <= camera_y;
            t_yadj  <= y_adjust;
            t_bx    <= base_x;
            t_by    <= base_y;
            if (kind == KIND_LOAD) begin
              // slot 0 restarts the animation
              if (frame_slot == '0) begin
                current_frame <= '0;
                play_backward <= 1'b0;
                loops_left    <= loop_count;
                next_due_ms   <= now_ms + 32'(frame_delay);
              end
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_x <= (scrolling && tick_seen) ?
                    ScrollSumW'(scroll_rate_x * $signed({1'b0, dt})) : '0;
          prod_y <= (scrolling && tick_seen) ?
                    ScrollSumW'(scroll_rate_y * $signed({1'b0, dt})) : '0;
          mul_px <= 33'(t_cam_x * $signed({1'b0, distance}));
          mul_py <= 33'(t_cam_y * $signed({1'b0, distance}));
          last_tick_ms <= t_now;
          tick_seen    <= 1'b1;
          adv_pend     <= adv;
          if (adv) begin
            current_frame <= cur_next[5:0];
            play_backward <= back_next;
            loops_left    <= loops_next;
          end
          state <= S_SUM;
        end
        S_SUM: begin
          sneg_x <= sum_x[ScrollSumW-1];
          sneg_y <= sum_y[ScrollSumW-1];
          mag_x  <= amag_x;
          mag_y  <= amag_y;
          slo_x  <= amag_x[SubpixShift-1:0];
          slo_y  <= amag_y[SubpixShift-1:0];
          srem_x <= '0;
          srem_y <= '0;
          sq_x   <= '0;
          sq_y   <= '0;
          sdig   <= '0;
          par_x  <= 19'(rnd_px >>> DistShift);
          par_y  <= 19'(rnd_py >>> DistShift);
          state  <= S_DIV1;
        end
        S_DIV1: begin
          if (sdig != 2'd3) begin
            srem_x <= rdf_x[6:0];
            srem_y <= rdf_y[6:0];
            sq_x   <= {sq_x[31-DigitW:0], qd_x};
            sq_y   <= {sq_y[31-DigitW:0], qd_y};
            mag_x  <= mag_x << DigitW;
            mag_y  <= mag_y << DigitW;
            sdig   <= sdig + 2'd1;
          end else begin
            frac_x <= sneg_x ? -$signed({1'b0, srem_x, slo_x}) :
                               $signed({1'b0, srem_x, slo_x});
            frac_y <= sneg_y ? -$signed({1'b0, srem_y, slo_y}) :
                               $signed({1'b0, srem_y, slo_y});
            pix_x  <= pix_x + whole_x;
            pix_y  <= pix_y + whole_y;
            state  <= S_WST;
          end
        end
        S_WST: begin
          wneg_x     <= pix_x[31];
          wneg_y     <= pix_y[31];
          wmag_x     <= pix_x[31] ? -pix_x : pix_x;
          wmag_y     <= pix_y[31] ? -pix_y : pix_y;
          wdiv_start <= 1'b1;
          state      <= S_DIV2;
        end
        S_DIV2: begin
          if (wdx_done && wdy_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (adv_pend) begin
            next_due_ms <= t_now + 32'(ram_rdata);
            adv_pend    <= 1'b0;
          end
          if (!out_valid || out_stall == 1'b0) begin
            out_valid   <= 1'b1;
            frame_index <= (n_frames != '0) ? current_frame : '0;
            dest_x      <= dx32;
            dest_y      <= dy32;
            second_copy <= copy_flag;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/alsq_checker.sv @@
// port-level checks for the sequencer core, bound to the top level
module alsq_checker
  import alsq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               kind,
  input logic [31:0]        now_ms,
  input logic signed [15:0] camera_x,
  input logic signed [15:0] camera_y,
  input logic signed [15:0] y_adjust,
  input logic signed [15:0] base_x,
  input logic signed [15:0] base_y,
  input logic [5:0]         frame_slot,
  input logic [15:0]        frame_delay,
  input logic               out_valid,
  input logic               out_stall,
  input logic [5:0]         frame_index,
  input logic signed [31:0] dest_x,
  input logic signed [31:0] dest_y,
  input logic               second_copy,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [31:0]        cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dest_x) && $stable(dest_y) &&
    $stable(frame_index) && $stable(second_copy))
    else $error("stalled result changed");

  // a tick keeps the input side busy afterwards
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == KIND_TICK |=> in_stall)
    else $error("tick transfer did not occupy the block");

  // a load never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == KIND_LOAD |=> !$rose(out_valid))
    else $error("load produced a result");

  // the block is free again right after a load
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == KIND_LOAD |=> !in_stall)
    else $error("load stalled the input");

endmodule

bind animated_layer_sequencer_core alsq_checker u_alsq_checker (.*);
